// ===== rtl/lsc_pkg.sv =====
// ============================================================================
// lsc_pkg - shared types and codes for the lift scan controller
// Word layouts for both channels, controller and event codes, and the
// control/status bundle between the sequencer and the front scanner.
// ============================================================================
package lsc_pkg;

    localparam int FLOOR_W    = 4;
    localparam int LIST_DEPTH = 2 ** FLOOR_W;

    typedef logic [FLOOR_W-1:0]    t_floor;
    typedef logic [LIST_DEPTH-1:0] t_floor_set;

    // input modes
    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_MOVED   = 2'd1;
    localparam logic [1:0] MODE_STOPPED = 2'd2;

    // controller states
    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_REQ  = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    // result kinds
    localparam logic [1:0] EV_ARRIVE = 2'd0;
    localparam logic [1:0] EV_MOVE   = 2'd1;
    localparam logic [1:0] EV_STOP   = 2'd2;
    localparam logic [1:0] EV_RESUME = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        t_floor     request_floor;
    } t_in_word;

    typedef struct packed {
        logic [1:0] event_kind;
        t_floor     floor_now;
        logic       last;
    } t_out_word;

    // sequencer -> scanner
    typedef struct packed {
        logic   start;
        logic   load_key;
        t_floor key_floor;
        logic   key_up;
    } t_scan_ctl;

    // scanner -> sequencer
    typedef struct packed {
        logic   busy;
        logic   done;
        t_floor front;
    } t_scan_sts;

endpackage

// ===== rtl/lsc_front_scan.sv =====
// ============================================================================
// lsc_front_scan - finds the head of the SCAN-ordered target set
// Walks floors one per cycle from the sort key floor in the key heading,
// then the floors behind, nearest first; the first pending floor is the front.
// ============================================================================
module lsc_front_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsc_pkg::t_scan_ctl i_ctl,
    input  lsc_pkg::t_floor_set i_pend,
    output lsc_pkg::t_scan_sts o_sts
);

    localparam lsc_pkg::t_floor FLOOR_MAX = lsc_pkg::t_floor'(lsc_pkg::LIST_DEPTH - 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic            r_phase, n_phase;
    lsc_pkg::t_floor r_ptr, n_ptr;
    lsc_pkg::t_floor r_probe, n_probe;
    lsc_pkg::t_floor r_front, n_front;
    lsc_pkg::t_floor r_key_floor, n_key_floor;
    logic            r_key_up, n_key_up;

    logic            hit;
    logic            at_end;
    lsc_pkg::t_floor key_floor;
    logic            key_up;

    assign hit = i_pend[r_ptr];
    assign at_end = r_key_up ? (r_ptr == FLOOR_MAX) : (r_ptr == '0);

    always_comb begin
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_phase     = r_phase;
        n_ptr       = r_ptr;
        n_probe     = r_probe;
        n_front     = r_front;
        n_key_floor = r_key_floor;
        n_key_up    = r_key_up;
        key_floor   = i_ctl.load_key ? i_ctl.key_floor : r_key_floor;
        key_up      = i_ctl.load_key ? i_ctl.key_up : r_key_up;

        if (i_ctl.start) begin
            n_key_floor = key_floor;
            n_key_up    = key_up;
            n_ptr       = key_floor;
            n_phase     = 1'b0;
            n_probe     = '0;
            n_busy      = 1'b1;
        end else if (r_busy) begin
            n_probe = r_probe + 1'b1;
            if (hit) begin
                n_front = r_ptr;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end else if (r_probe == FLOOR_MAX) begin
                // every floor probed: nothing pending
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_phase && at_end) begin
                // ahead side exhausted, go to the nearest floor behind
                n_phase = 1'b1;
                n_ptr   = r_key_up ? r_key_floor - 1'b1 : r_key_floor + 1'b1;
            end else if (r_phase ^ r_key_up) begin
                n_ptr = r_ptr + 1'b1;
            end else begin
                n_ptr = r_ptr - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_phase     <= n_phase;
        r_ptr       <= n_ptr;
        r_probe     <= n_probe;
        r_front     <= n_front;
        r_key_floor <= n_key_floor;
        r_key_up    <= n_key_up;
    end

    assign o_sts = '{busy: r_busy, done: r_done, front: r_front};

endmodule

// ===== rtl/lift_scan_controller_core.sv =====
// ============================================================================
// lift_scan_controller_core - SCAN-ordered lift controller
// Takes floor requests and cabin moved / stop finished events, keeps the
// pending floors in SCAN order and issues arrive, move, stop, resume words.
// ============================================================================
// One input word at a time. An accepted word holds the input stall high
// until all of its result words (zero, one or two, the final one flagged
// by last) have been taken. Each word is taken, then evaluated, with one
// front-scan pass before evaluation when a new floor is added and one after
// it when the front floor is served while others remain; its result words
// then go out one per cycle while the output is not stalled. A scan pass
// probes one floor per cycle.
// Pending floors are held as one bit per floor; the SCAN order is fixed by
// the cabin floor and heading at the time the last new floor was added, so
// serving the front does not reorder the rest. No clearing pass is needed.
// ============================================================================
module lift_scan_controller_core #(
    parameter int NUM_FLOORS  = 16,
    parameter int START_FLOOR = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  lsc_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    // output channel
    output logic               o_out_valid,
    output lsc_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    // top floor is capped by the 4-bit floor field
    localparam int TOP_INT   = (NUM_FLOORS > lsc_pkg::LIST_DEPTH) ?
                               (lsc_pkg::LIST_DEPTH - 1) : (NUM_FLOORS - 1);
    localparam int RESET_INT = (START_FLOOR > TOP_INT) ? TOP_INT : START_FLOOR;
    localparam lsc_pkg::t_floor TOP_FLOOR   = lsc_pkg::t_floor'(TOP_INT);
    localparam lsc_pkg::t_floor RESET_FLOOR = lsc_pkg::t_floor'(RESET_INT);

    // sequencer codes
    localparam logic [2:0] SQ_IDLE     = 3'd0;
    localparam logic [2:0] SQ_SCAN_ADD = 3'd1;
    localparam logic [2:0] SQ_EXEC     = 3'd2;
    localparam logic [2:0] SQ_SCAN_REM = 3'd3;
    localparam logic [2:0] SQ_EMIT     = 3'd4;

    logic [2:0]          r_seq, n_seq;
    logic [1:0]          r_state, n_state;   // controller state
    logic                r_up, n_up;         // heading, 1 = up
    lsc_pkg::t_floor     r_cab, n_cab;       // cabin floor
    lsc_pkg::t_floor_set r_pend, n_pend;     // pending floors
    lsc_pkg::t_in_word   r_item, n_item;     // word in work
    logic [1:0]          r_kind0, n_kind0;
    logic [1:0]          r_kind1, n_kind1;
    logic [1:0]          r_nres, n_nres;
    logic                r_emit_idx, n_emit_idx;

    lsc_pkg::t_scan_ctl  scan_ctl;
    lsc_pkg::t_scan_sts  scan_sts;

    logic            in_take;
    logic            out_take;
    logic            out_last;
    logic            add_new;
    lsc_pkg::t_floor front;

    // evaluate-cycle results
    logic [1:0]          x_state;
    logic                x_up;
    lsc_pkg::t_floor     x_cab;
    logic                x_remove;
    logic [1:0]          x_nres;
    logic [1:0]          x_k0;
    logic [1:0]          x_k1;
    logic [1:0]          x_tail;
    lsc_pkg::t_floor_set x_pend;

    assign front    = scan_sts.front;
    assign in_take  = (r_seq == SQ_IDLE) && i_in_valid;
    assign out_take = o_out_valid && !i_out_stall;
    assign out_last = r_emit_idx || (r_nres == 2'd1);

    // new in-range floor not already pending
    assign add_new = (i_in_word.mode == lsc_pkg::MODE_REQUEST) &&
                     (i_in_word.request_floor <= TOP_FLOOR) &&
                     !r_pend[i_in_word.request_floor];

    // ---- evaluation of one word against the current front ----
    always_comb begin
        x_state  = r_state;
        x_up     = r_up;
        x_cab    = r_cab;
        x_remove = 1'b0;
        x_nres   = 2'd0;
        x_k0     = lsc_pkg::EV_ARRIVE;
        x_k1     = lsc_pkg::EV_ARRIVE;
        x_tail   = lsc_pkg::EV_MOVE;

        case (r_item.mode)
            lsc_pkg::MODE_REQUEST: begin
                if (r_item.request_floor <= TOP_FLOOR) begin
                    x_state = lsc_pkg::ST_REQ;
                    if (r_cab == r_item.request_floor) begin
                        // already there: stop handling
                        x_state = lsc_pkg::ST_STOP;
                        x_nres  = 2'd1;
                        if (r_cab == front) begin
                            x_remove = 1'b1;
                            x_k0     = lsc_pkg::EV_STOP;
                        end else begin
                            x_k0 = lsc_pkg::EV_RESUME;
                        end
                    end else if (r_state == lsc_pkg::ST_WAIT) begin
                        // idle cabin starts a trip; no floor step here
                        x_state = lsc_pkg::ST_MOVE;
                        x_nres  = 2'd1;
                        if (r_cab < front && !r_up) begin
                            x_up = 1'b1;
                        end else if (r_cab > front && r_up) begin
                            x_up = 1'b0;
                        end
                        if (r_cab == front) begin
                            x_state  = lsc_pkg::ST_STOP;
                            x_remove = 1'b1;
                            x_k0     = lsc_pkg::EV_STOP;
                        end else begin
                            x_k0 = lsc_pkg::EV_MOVE;
                        end
                    end
                end
            end
            lsc_pkg::MODE_MOVED, lsc_pkg::MODE_STOPPED: begin
                if (r_state != lsc_pkg::ST_WAIT) begin
                    if (r_state == lsc_pkg::ST_MOVE) begin
                        // step one floor, saturating at both ends
                        if (r_up) begin
                            x_cab = (r_cab < TOP_FLOOR) ? r_cab + 1'b1 : r_cab;
                        end else begin
                            x_cab = (r_cab != '0) ? r_cab - 1'b1 : r_cab;
                        end
                        x_k0   = lsc_pkg::EV_ARRIVE;
                        x_nres = 2'd1;
                    end
                    x_state = lsc_pkg::ST_MOVE;
                    if (r_pend == '0) begin
                        x_state = lsc_pkg::ST_WAIT;
                    end else begin
                        if (x_cab < front && !r_up) begin
                            x_up = 1'b1;
                        end else if (x_cab > front && r_up) begin
                            x_up = 1'b0;
                        end
                        if (x_cab == front) begin
                            x_state  = lsc_pkg::ST_STOP;
                            x_remove = 1'b1;
                            x_tail   = lsc_pkg::EV_STOP;
                        end else begin
                            x_tail = lsc_pkg::EV_MOVE;
                        end
                        if (r_state == lsc_pkg::ST_MOVE) begin
                            x_k1   = x_tail;
                            x_nres = 2'd2;
                        end else begin
                            x_k0   = x_tail;
                            x_nres = 2'd1;
                        end
                    end
                end
            end
            default: begin
                // unused mode: no effect
            end
        endcase

        x_pend = r_pend;
        if (x_remove) begin
            x_pend = r_pend & ~(lsc_pkg::t_floor_set'(1) << front);
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_seq      = r_seq;
        n_state    = r_state;
        n_up       = r_up;
        n_cab      = r_cab;
        n_pend     = r_pend;
        n_item     = r_item;
        n_kind0    = r_kind0;
        n_kind1    = r_kind1;
        n_nres     = r_nres;
        n_emit_idx = r_emit_idx;
        scan_ctl   = '{start: 1'b0, load_key: 1'b0, key_floor: r_cab, key_up: r_up};

        case (r_seq)
            SQ_IDLE: begin
                if (in_take) begin
                    n_item = i_in_word;
                    if (add_new) begin
                        // new floor: the set is re-ordered around the cabin now
                        n_pend = r_pend |
                                 (lsc_pkg::t_floor_set'(1) << i_in_word.request_floor);
                        scan_ctl.start    = 1'b1;
                        scan_ctl.load_key = 1'b1;
                        n_seq = SQ_SCAN_ADD;
                    end else begin
                        n_seq = SQ_EXEC;
                    end
                end
            end
            SQ_SCAN_ADD: begin
                if (scan_sts.done) begin
                    n_seq = SQ_EXEC;
                end
            end
            SQ_EXEC: begin
                n_state    = x_state;
                n_up       = x_up;
                n_cab      = x_cab;
                n_pend     = x_pend;
                n_kind0    = x_k0;
                n_kind1    = x_k1;
                n_nres     = x_nres;
                n_emit_idx = 1'b0;
                if (x_remove && (x_pend != '0)) begin
                    // front served: find the next one in the same order
                    scan_ctl.start = 1'b1;
                    n_seq = SQ_SCAN_REM;
                end else if (x_nres != 2'd0) begin
                    n_seq = SQ_EMIT;
                end else begin
                    n_seq = SQ_IDLE;
                end
            end
            SQ_SCAN_REM: begin
                if (scan_sts.done) begin
                    n_seq = (r_nres != 2'd0) ? SQ_EMIT : SQ_IDLE;
                end
            end
            SQ_EMIT: begin
                if (out_take) begin
                    if (out_last) begin
                        n_seq = SQ_IDLE;
                    end else begin
                        n_emit_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SQ_IDLE;
            r_state <= lsc_pkg::ST_WAIT;
            r_up    <= 1'b1;
            r_cab   <= RESET_FLOOR;
            r_pend  <= '0;
        end else begin
            r_seq   <= n_seq;
            r_state <= n_state;
            r_up    <= n_up;
            r_cab   <= n_cab;
            r_pend  <= n_pend;
        end
        r_item     <= n_item;
        r_kind0    <= n_kind0;
        r_kind1    <= n_kind1;
        r_nres     <= n_nres;
        r_emit_idx <= n_emit_idx;
    end

    lsc_front_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_pend  (r_pend),
        .o_sts   (scan_sts)
    );

    // ---- ports ----
    assign o_in_stall  = (r_seq != SQ_IDLE);
    assign o_out_valid = (r_seq == SQ_EMIT);
    assign o_out_word  = '{event_kind: (r_emit_idx ? r_kind1 : r_kind0),
                           floor_now:  r_cab,
                           last:       out_last};

    // ---- assertions ----
    a_cab_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cab <= TOP_FLOOR)
        else $error("cabin floor beyond top floor");

    a_scan_hit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_sts.done && (r_seq == SQ_SCAN_ADD || r_seq == SQ_SCAN_REM))
        |-> r_pend[scan_sts.front])
        else $error("scan returned a floor that is not pending");

    a_remove_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_EXEC && x_remove) |-> r_pend[front])
        else $error("served floor was not pending");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> (r_seq == SQ_SCAN_ADD || r_seq == SQ_SCAN_REM))
        else $error("scan finished outside a scan step");

    a_emit_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_nres != 2'd0 && (!r_emit_idx || r_nres == 2'd2)))
        else $error("result word without a pending result");

endmodule
